/* hw/rtl/bba_pkg.sv */
package bba_pkg;

  // heap geometry: 2^(LEVELS-1) leaves of LEAF_BYTES bytes
  localparam int LEVELS     = 11;
  localparam int LEAF_BYTES = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_A_SCAN,
    S_A_POP_RD,
    S_A_BIT_RD,
    S_A_POP_WR,
    S_A_SPLIT,
    S_A_PUSH_WR,
    S_F_FIND_RD,
    S_F_FIND,
    S_F_MERGE_RD,
    S_F_MERGE,
    S_F_UNL_RD,
    S_F_UNL_WR,
    S_F_PUSH_WR,
    S_DONE,
    S_ERR
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic pop_rd;
    logic bit_rd;
    logic pop_wr;
    logic split_step;
    logic push_wr;
    logic find_step;
    logic merge_step;
    logic unl_rd;
    logic unl_wr;
    logic emit_ok;
    logic emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic too_big;
    logic scan_hit;
    logic scan_end;
    logic split_more;
    logic find_hit;
    logic find_end;
    logic merge_stop;
  } dp_sts_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

/* hw/rtl/bba_ctrl.sv */
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output bba_pkg::dp_cmd_t  cmd,
  input  bba_pkg::dp_sts_t  sts
);

  bba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bba_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != bba_pkg::S_IDLE);
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = sts.is_free ? bba_pkg::S_F_FIND_RD :
                      (sts.too_big ? bba_pkg::S_ERR : bba_pkg::S_A_SCAN);
        end
      end
      bba_pkg::S_A_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) state_nxt = bba_pkg::S_A_POP_RD;
        else if (sts.scan_end) state_nxt = bba_pkg::S_ERR;
      end
      bba_pkg::S_A_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt = bba_pkg::S_A_BIT_RD;
      end
      bba_pkg::S_A_BIT_RD: begin
        cmd.bit_rd = 1'b1;
        state_nxt = bba_pkg::S_A_POP_WR;
      end
      bba_pkg::S_A_POP_WR: begin
        cmd.pop_wr = 1'b1;
        state_nxt = sts.split_more ? bba_pkg::S_A_SPLIT : bba_pkg::S_DONE;
      end
      bba_pkg::S_A_SPLIT: begin
        cmd.split_step = 1'b1;
        state_nxt = bba_pkg::S_A_PUSH_WR;
      end
      bba_pkg::S_A_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        state_nxt = sts.split_more ? bba_pkg::S_A_SPLIT : bba_pkg::S_DONE;
      end
      bba_pkg::S_F_FIND_RD: begin
        cmd.bit_rd = 1'b1;
        state_nxt = bba_pkg::S_F_FIND;
      end
      bba_pkg::S_F_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.find_hit || sts.find_end) state_nxt = bba_pkg::S_F_MERGE_RD;
        else state_nxt = bba_pkg::S_F_FIND_RD;
      end
      bba_pkg::S_F_MERGE_RD: begin
        cmd.bit_rd = 1'b1;
        state_nxt = bba_pkg::S_F_MERGE;
      end
      bba_pkg::S_F_MERGE: begin
        cmd.merge_step = 1'b1;
        state_nxt = sts.merge_stop ? bba_pkg::S_F_PUSH_WR : bba_pkg::S_F_UNL_RD;
      end
      bba_pkg::S_F_UNL_RD: begin
        cmd.unl_rd = 1'b1;
        state_nxt = bba_pkg::S_F_UNL_WR;
      end
      bba_pkg::S_F_UNL_WR: begin
        cmd.unl_wr = 1'b1;
        state_nxt = bba_pkg::S_F_MERGE_RD;
      end
      bba_pkg::S_F_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        cmd.emit_ok = 1'b1;
        state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_ERR: begin
        cmd.emit_err = 1'b1;
        state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/bba_dp.sv */
module bba_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_sts_t  sts,
  input  logic              in_command,
  input  logic [15:0]       in_request_bytes,
  input  logic [13:0]       in_free_offset,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [13:0]       out_block_offset,
  output logic [3:0]        out_block_level
);

  localparam int LEVELS     = bba_pkg::LEVELS;
  localparam int LEAF_BYTES = bba_pkg::LEAF_BYTES;
  localparam int TOP   = LEVELS - 1;
  localparam int NW    = LEVELS;         // node index width
  localparam int LW    = LEVELS - 1;     // leaf index width
  localparam int KW    = $clog2(LEVELS + 1);
  localparam int NODES = 1 << LEVELS;
  localparam int INNER = 1 << (LEVELS - 1);
  localparam int IW    = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int CW    = IW + 1;
  localparam int LSH   = $clog2(LEAF_BYTES);

  // link memories (undefined until written), split / pair bits (cleared by sweep)
  logic [NW-1:0] next_mem [NODES];
  logic [NW-1:0] prev_mem [NODES];
  logic          split_mem [INNER];
  logic          xor_mem [INNER];
  logic [NW-1:0] head_r [LEVELS];

  logic [CW-1:0] clr_r;
  logic [KW-1:0] k_r, fk_r;
  logic [LW-1:0] leaf_r;
  logic [NW-1:0] node_r, rd_next_r, rd_prev_r;
  logic          sbit_r, xbit_r;
  logic          valid_r;
  logic [1:0]    status_r;
  logic [13:0]   off_r;
  logic [3:0]    lvl_r;
  logic          cmd_r;
  logic          req_big_r;

  function automatic logic [NW-1:0] node_of(input logic [KW-1:0] lvl,
                                            input logic [LW-1:0] leaf);
    logic [NW-1:0] b;
    logic [NW-1:0] s;
    b = {{(NW-1){1'b0}}, 1'b1} << (NW'(TOP) - NW'(lvl));
    s = {1'b0, leaf} >> lvl;
    return b + s;
  endfunction

  // request level: smallest fk with LEAF_BYTES<<fk >= bytes
  logic [KW-1:0] req_lvl;
  logic          req_big;
  always_comb begin
    logic [31:0] sz;
    req_lvl = KW'(LEVELS);
    req_big = 1'b1;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      sz = 32'(LEAF_BYTES) << i;
      if (sz >= {16'd0, in_request_bytes}) begin
        req_lvl = KW'(i);
        req_big = 1'b0;
      end
    end
  end

  // working addresses
  logic [NW-1:0] cur_node;       // node at level k_r of leaf_r
  logic [NW-1:0] parent_node;    // node at level k_r+1
  logic [LW-1:0] buddy_leaf;
  logic [NW-1:0] buddy_node;
  logic [IW-1:0] par_idx, cur_idx;
  logic [LW-1:0] kbit;
  logic [KW-1:0] k_m1, k_p1;

  assign k_m1       = k_r - KW'(1);
  assign k_p1       = k_r + KW'(1);
  assign kbit       = LW'(1) << k_r;
  assign cur_node   = node_of(k_r, leaf_r);
  assign parent_node = node_of(k_p1, leaf_r);
  assign buddy_leaf = leaf_r ^ kbit;
  assign buddy_node = node_of(k_r, buddy_leaf);
  assign par_idx    = IW'(parent_node);
  assign cur_idx    = IW'(cur_node);

  logic [LW-1:0] pop_leaf;
  logic [NW-1:0] pop_n;
  assign pop_n    = head_r[k_r];
  assign pop_leaf = LW'((pop_n - (NW'(1) << (NW'(TOP) - NW'(k_r)))) << k_r);

  logic [LW-1:0] in_leaf;
  assign in_leaf = LW'(in_free_offset >> LSH);

  logic fk_r_is_alloc;
  logic [NW-1:0] push_n;
  logic [KW-1:0] push_k;
  assign fk_r_is_alloc = (cmd_r == bba_pkg::CMD_ALLOC);
  // alloc pushes the upper buddy (k_r already stepped down); free pushes the merged block
  assign push_k = k_r;
  assign push_n = fk_r_is_alloc ? buddy_node : cur_node;

  assign sts.clear_done = (clr_r == CW'(INNER - 1));
  assign sts.is_free    = (in_command == bba_pkg::CMD_FREE);
  assign sts.too_big    = req_big;
  assign sts.scan_hit   = (head_r[k_r] != '0);
  assign sts.scan_end   = (k_r == KW'(TOP));
  assign sts.split_more = (k_r > fk_r);
  assign sts.find_hit   = sbit_r;
  assign sts.find_end   = (k_p1 >= KW'(TOP));
  assign sts.merge_stop = (k_r >= KW'(TOP)) || (xbit_r == 1'b0);

  // bit memories: registered read at the parent node, then update
  always_ff @(posedge clk) begin
    if (cmd.bit_rd) begin
      sbit_r <= split_mem[par_idx];
      xbit_r <= xor_mem[par_idx];
    end
    if (cmd.clear_step) begin
      split_mem[IW'(clr_r)] <= 1'b0;
      xor_mem[IW'(clr_r)]   <= 1'b0;
    end
    if (cmd.pop_wr && (k_r < KW'(TOP)))
      xor_mem[par_idx] <= ~xbit_r;
    if (cmd.split_step) begin
      split_mem[cur_idx] <= 1'b1;
      xor_mem[cur_idx]   <= 1'b1;
    end
    if (cmd.merge_step && (k_r < KW'(TOP))) begin
      xor_mem[par_idx] <= ~xbit_r;
      if (xbit_r) split_mem[par_idx] <= 1'b0;
    end
  end

  // links: writes sequenced by the controller; push and unlink each update several link entries at once
  always_ff @(posedge clk) begin
    if (cmd.pop_rd) rd_next_r <= next_mem[pop_n];
    if (cmd.unl_rd) begin
      rd_next_r <= next_mem[node_r];
      rd_prev_r <= prev_mem[node_r];
    end
    if (cmd.pop_wr && rd_next_r != '0) prev_mem[rd_next_r] <= '0;
    if (cmd.push_wr) begin
      next_mem[push_n] <= head_r[push_k];
      prev_mem[push_n] <= '0;
      if (head_r[push_k] != '0) prev_mem[head_r[push_k]] <= push_n;
    end
    if (cmd.unl_wr) begin
      if (head_r[k_r] != node_r && rd_prev_r != '0) next_mem[rd_prev_r] <= rd_next_r;
      if (rd_next_r != '0) prev_mem[rd_next_r] <= rd_prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) head_r[i] <= '0;
      head_r[TOP] <= NW'(1);
    end else begin
      valid_r <= cmd.emit_ok || cmd.emit_err;
      if (cmd.clear_step) clr_r <= clr_r + CW'(1);
      if (cmd.load) begin
        cmd_r <= in_command;
        fk_r  <= req_lvl;
        k_r   <= in_command ? KW'(0) : req_lvl;
        leaf_r <= in_leaf;
      end
      if (cmd.scan_step && !sts.scan_hit && !sts.scan_end) k_r <= k_p1;
      if (cmd.pop_rd) leaf_r <= pop_leaf;
      if (cmd.pop_wr) head_r[k_r] <= rd_next_r;
      if (cmd.split_step) k_r <= k_m1;
      if (cmd.push_wr) head_r[push_k] <= push_n;
      if (cmd.find_step) begin
        if (sts.find_hit) begin
          leaf_r <= leaf_r & ~(kbit - LW'(1));
        end else if (sts.find_end) begin
          k_r    <= KW'(TOP);
          leaf_r <= '0;
        end else k_r <= k_p1;
      end
      if (cmd.merge_step) node_r <= buddy_node;
      if (cmd.unl_wr) begin
        if (head_r[k_r] == node_r) head_r[k_r] <= rd_next_r;
        leaf_r <= leaf_r & ~kbit;
        k_r    <= k_p1;
      end
      if (cmd.emit_ok) begin
        status_r <= bba_pkg::ST_OK;
        off_r    <= 14'({{(32-LW){1'b0}}, leaf_r} * LEAF_BYTES);
        lvl_r    <= 4'(fk_r_is_alloc ? fk_r : k_r);
      end
      if (cmd.emit_err) begin
        status_r <= req_big_r ? bba_pkg::ST_TOO_BIG : bba_pkg::ST_NO_FREE;
        off_r    <= '0;
        lvl_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_big_r <= req_big;
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_block_offset = off_r;
  assign out_block_level  = lvl_r;

endmodule

/* hw/rtl/buddy_block_allocator.sv */
// Buddy allocator over 2^(LEVELS-1) leaves of LEAF_BYTES bytes (package constants,
// 1024 x 16 bytes). A transaction is taken when start is high and busy is low; its
// one result is on the out_ ports for a single cycle, flagged by out_valid, and the
// receiver cannot stall. After reset the block stays busy while the split and pair
// bits are cleared. Allocate scans up from the requested level, pops the head and
// splits down, pushing each upper buddy; with no free block it ends after the scan,
// and an oversize request goes straight to the error. Free searches up for a split
// bit, then merges level by level; a free that merges all the way up is the longest.
// Pops, searches and merges do a registered read of the bit or link memories first.
// busy drops in the cycle the result shows, so the next transaction can be taken then.
module buddy_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_request_bytes,
  input  logic [13:0] in_free_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [13:0] out_block_offset,
  output logic [3:0]  out_block_level
);

  bba_pkg::dp_cmd_t cmd;
  bba_pkg::dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  bba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_free_offset(in_free_offset), .out_valid(out_valid),
    .out_status(out_status), .out_block_offset(out_block_offset),
    .out_block_level(out_block_level)
  );

endmodule

/* hw/rtl/bba_checker.sv */
module bba_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [13:0] out_block_offset,
  input logic [3:0] out_block_level
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held longer than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bba_pkg::ST_OK) |->
      (out_block_offset == '0 && out_block_level == '0))
    else $error("error result with nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bba_pkg::ST_OK || out_status == bba_pkg::ST_NO_FREE ||
                   out_status == bba_pkg::ST_TOO_BIG)) else $error("bad status code");

endmodule

bind buddy_block_allocator bba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_block_offset(out_block_offset),
  .out_block_level(out_block_level)
);
